>>> rtl/core/lss_pkg.sv
// shared types and constants for the lifo stack with search
package lss_pkg;

   // field widths fixed by the transaction format
   localparam int unsigned DATA_W = 32;
   localparam int unsigned POS_W  = 4;

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_SEARCH  = 2'd2,
      OP_DISPLAY = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type               opcode;
      logic signed [DATA_W-1:0] operand;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic        [POS_W-1:0]  position;
      logic                     last;
   } rsp_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK
   } state_type;

   // which result the datapath loads into the output register
   typedef enum logic [2:0] {
      SEL_PUSH,
      SEL_OVERFLOW,
      SEL_EMPTY,
      SEL_POP,
      SEL_HIT,
      SEL_MISS,
      SEL_DISP
   } out_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic        op_load;
      logic        mem_wr;
      logic        fill_inc;
      logic        fill_dec;
      logic        ptr_load;
      logic        ptr_dec;
      logic        pos_inc;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic full;
      logic empty;
      logic match;
      logic at_bottom;
      logic out_free;
   } stat_type;

endpackage

>>> rtl/core/lss_ctrl.sv
// controller state machine for the lifo stack with search
module lss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lss_pkg::opcode_type req_opcode,
   input  lss_pkg::stat_type   stat,
   output lss_pkg::cmd_type    cmd
);

   lss_pkg::state_type  state_ff, state_in;
   lss_pkg::opcode_type op_ff;
   logic                accept;

   // input handshake, only when idle and the output register has room
   assign req_ready = (state_ff == lss_pkg::ST_IDLE) && stat.out_free;
   assign accept    = req_valid && req_ready;

   // state and opcode registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_opcode;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lss_pkg::ST_IDLE: begin
            if (accept && (req_opcode != lss_pkg::OP_PUSH) && !stat.empty) begin
               state_in = lss_pkg::ST_FETCH;
            end
         end
         lss_pkg::ST_FETCH: begin
            state_in = lss_pkg::ST_CHECK;
         end
         lss_pkg::ST_CHECK: begin
            case (op_ff)
               lss_pkg::OP_POP: begin
                  if (stat.out_free) begin
                     state_in = lss_pkg::ST_IDLE;
                  end
               end
               lss_pkg::OP_SEARCH: begin
                  if (stat.match || stat.at_bottom) begin
                     if (stat.out_free) begin
                        state_in = lss_pkg::ST_IDLE;
                     end
                  end else begin
                     state_in = lss_pkg::ST_FETCH;
                  end
               end
               lss_pkg::OP_DISPLAY: begin
                  if (stat.out_free) begin
                     state_in = stat.at_bottom ? lss_pkg::ST_IDLE : lss_pkg::ST_FETCH;
                  end
               end
               default: begin
                  state_in = lss_pkg::ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = lss_pkg::ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd         = '0;
      cmd.out_sel = lss_pkg::SEL_EMPTY;
      case (state_ff)
         lss_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.op_load = 1'b1;
               case (req_opcode)
                  lss_pkg::OP_PUSH: begin
                     cmd.out_load = 1'b1;
                     if (stat.full) begin
                        cmd.out_sel = lss_pkg::SEL_OVERFLOW;
                     end else begin
                        cmd.mem_wr   = 1'b1;
                        cmd.fill_inc = 1'b1;
                        cmd.out_sel  = lss_pkg::SEL_PUSH;
                     end
                  end
                  lss_pkg::OP_POP: begin
                     if (stat.empty) begin
                        cmd.out_load = 1'b1;
                     end else begin
                        cmd.fill_dec = 1'b1;
                        cmd.ptr_load = 1'b1;
                     end
                  end
                  default: begin
                     if (stat.empty) begin
                        cmd.out_load = 1'b1;
                     end else begin
                        cmd.ptr_load = 1'b1;
                     end
                  end
               endcase
            end
         end
         lss_pkg::ST_CHECK: begin
            case (op_ff)
               lss_pkg::OP_POP: begin
                  cmd.out_sel  = lss_pkg::SEL_POP;
                  cmd.out_load = stat.out_free;
               end
               lss_pkg::OP_SEARCH: begin
                  if (stat.match) begin
                     cmd.out_sel  = lss_pkg::SEL_HIT;
                     cmd.out_load = stat.out_free;
                  end else if (stat.at_bottom) begin
                     cmd.out_sel  = lss_pkg::SEL_MISS;
                     cmd.out_load = stat.out_free;
                  end else begin
                     cmd.ptr_dec = 1'b1;
                     cmd.pos_inc = 1'b1;
                  end
               end
               lss_pkg::OP_DISPLAY: begin
                  cmd.out_sel  = lss_pkg::SEL_DISP;
                  cmd.out_load = stat.out_free;
                  cmd.ptr_dec  = stat.out_free && !stat.at_bottom;
               end
               default: begin
                  cmd.out_load = 1'b0;
               end
            endcase
         end
         default: begin
            cmd.out_load = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/core/lss_dp.sv
// datapath for the lifo stack with search: storage, pointers and result register
module lss_dp #(
   parameter int unsigned DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  lss_pkg::req_type  req_data,
   input  lss_pkg::cmd_type  cmd,
   output lss_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lss_pkg::rsp_type  rsp_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FW = $clog2(DEPTH + 1);

   logic signed [lss_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [lss_pkg::DATA_W-1:0] rd_ff;
   logic signed [lss_pkg::DATA_W-1:0] op_ff;
   logic        [FW-1:0]              fill_ff;
   logic        [AW-1:0]              ptr_ff;
   logic        [lss_pkg::POS_W-1:0]  pos_ff;
   logic                              rsp_valid_ff;
   lss_pkg::rsp_type                  rsp_ff, rsp_in;

   // storage, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[fill_ff[AW-1:0]] <= req_data.operand;
      end
      rd_ff <= mem[ptr_ff];
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.fill_inc) begin
         fill_ff <= fill_ff + FW'(1);
      end else if (cmd.fill_dec) begin
         fill_ff <= fill_ff - FW'(1);
      end
   end

   // operand, scan pointer and hit position
   always_ff @(posedge clock) begin
      if (cmd.op_load) begin
         op_ff <= req_data.operand;
      end
      if (cmd.ptr_load) begin
         ptr_ff <= AW'(fill_ff - FW'(1));
         pos_ff <= lss_pkg::POS_W'(1);
      end else begin
         if (cmd.ptr_dec) begin
            ptr_ff <= ptr_ff - AW'(1);
         end
         if (cmd.pos_inc) begin
            pos_ff <= pos_ff + lss_pkg::POS_W'(1);
         end
      end
   end

   // status towards the controller
   always_comb begin
      stat.full      = (fill_ff == FW'(DEPTH));
      stat.empty     = (fill_ff == '0);
      stat.match     = (rd_ff == op_ff);
      stat.at_bottom = (ptr_ff == '0);
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // result selection
   always_comb begin
      rsp_in          = '0;
      rsp_in.last     = 1'b1;
      rsp_in.status   = lss_pkg::STAT_OK;
      case (cmd.out_sel)
         lss_pkg::SEL_PUSH: begin
            rsp_in.data = req_data.operand;
         end
         lss_pkg::SEL_OVERFLOW: begin
            rsp_in.status = lss_pkg::STAT_OVERFLOW;
         end
         lss_pkg::SEL_EMPTY: begin
            rsp_in.status = lss_pkg::STAT_EMPTY;
         end
         lss_pkg::SEL_POP: begin
            rsp_in.data = rd_ff;
         end
         lss_pkg::SEL_HIT: begin
            rsp_in.data     = op_ff;
            rsp_in.position = pos_ff;
         end
         lss_pkg::SEL_MISS: begin
            rsp_in.status = lss_pkg::STAT_NOTFOUND;
            rsp_in.data   = op_ff;
         end
         lss_pkg::SEL_DISP: begin
            rsp_in.data = rd_ff;
            rsp_in.last = (ptr_ff == '0);
         end
         default: begin
            rsp_in.status = lss_pkg::STAT_EMPTY;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/lifo_stack_with_search.sv
// top level of the lifo stack with search
// Bounded LIFO stack of DEPTH signed 32-bit words, one operation per request
// transaction: push, pop, search from the top, or display top to bottom. Words
// sit in a single-port-read memory with a registered read, and a controller
// walks it one word at a time. A push, and any operation on an empty stack or a
// push onto a full one, answers with its response in the cycle after the
// request is taken. A pop reads the top word in FETCH and loads it out in CHECK;
// a search passes FETCH and CHECK for each word examined (at most fill count).
// Display gives fill count responses, the last one flagged, each word read in
// FETCH and sent from CHECK. Position is 1-based from the top and wraps at 16.
// After reset the stack is empty and ready at once; no clearing pass is needed.
module lifo_stack_with_search #(
   parameter int unsigned DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lss_pkg::rsp_type rsp_data
);

   lss_pkg::cmd_type  cmd;
   lss_pkg::stat_type stat;

   // sequencing
   lss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   // storage and result path
   lss_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/tb_lifo_stack_with_search.sv
// self-checking testbench for the lifo stack with search
module tb_lifo_stack_with_search;
   import lss_pkg::*;

   localparam int unsigned DEPTH       = 8;
   localparam int unsigned QUIET_LIMIT = 5000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned TAIL_CYCLES = 40;

   // idling regimes for the two channels
   typedef enum logic [2:0] {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE,
      PH_BACKPRESSURE
   } idle_phase_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   idle_phase_type phase = PH_STEADY;

   // software copy of the stack and the results it owes
   logic signed [DATA_W-1:0] stack_words [DEPTH];
   int unsigned              stack_fill = 0;
   req_type                  pending_reqs [$];
   rsp_type                  expected_rsps [$];

   int unsigned errors         = 0;
   int unsigned op_counts [4]  = '{0, 0, 0, 0};
   int unsigned results_seen   = 0;
   int unsigned overflow_count = 0;
   int unsigned empty_count    = 0;
   int unsigned hit_count      = 0;
   int unsigned miss_count     = 0;
   int unsigned hold_left      = 0;
   bit          hold_done      = 1'b0;
   int unsigned quiet_cycles   = 0;

   lifo_stack_with_search #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock and reset
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic req_type make_req(opcode_type op, logic signed [DATA_W-1:0] value);
      req_type r;
      r.opcode  = op;
      r.operand = value;
      return r;
   endfunction

   function automatic rsp_type make_rsp(status_type st, logic signed [DATA_W-1:0] value,
                                        int unsigned pos, logic lst);
      rsp_type r;
      r.status   = st;
      r.data     = value;
      r.position = pos[POS_W-1:0];
      r.last     = lst;
      return r;
   endfunction

   function automatic int unsigned sender_idle_pct(idle_phase_type ph);
      case (ph)
         PH_SENDER_IDLE: return 71;
         PH_BOTH_IDLE:   return 11;
         default:        return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_stall_pct(idle_phase_type ph);
      case (ph)
         PH_RECEIVER_STALL: return 71;
         PH_BOTH_IDLE:      return 11;
         default:           return 0;
      endcase
   endfunction

   // apply one accepted operation to the software stack, queue its results
   task automatic predict_stack_op(input req_type item);
      int unsigned i;
      bit          hit;
      hit = 1'b0;
      case (item.opcode)
         OP_PUSH: begin
            if (stack_fill >= DEPTH) begin
               expected_rsps.push_back(make_rsp(STAT_OVERFLOW, '0, 0, 1'b1));
               overflow_count++;
            end else begin
               stack_words[stack_fill] = item.operand;
               stack_fill++;
               expected_rsps.push_back(make_rsp(STAT_OK, item.operand, 0, 1'b1));
            end
         end
         OP_POP: begin
            if (stack_fill == 0) begin
               expected_rsps.push_back(make_rsp(STAT_EMPTY, '0, 0, 1'b1));
               empty_count++;
            end else begin
               stack_fill--;
               expected_rsps.push_back(make_rsp(STAT_OK, stack_words[stack_fill], 0, 1'b1));
            end
         end
         OP_SEARCH: begin
            if (stack_fill == 0) begin
               expected_rsps.push_back(make_rsp(STAT_EMPTY, '0, 0, 1'b1));
               empty_count++;
            end else begin
               // first match counted from the top wins
               for (i = 0; i < stack_fill && !hit; i++) begin
                  if (stack_words[stack_fill - 1 - i] == item.operand) begin
                     hit = 1'b1;
                     expected_rsps.push_back(make_rsp(STAT_OK, item.operand, i + 1, 1'b1));
                     hit_count++;
                  end
               end
               if (!hit) begin
                  expected_rsps.push_back(make_rsp(STAT_NOTFOUND, item.operand, 0, 1'b1));
                  miss_count++;
               end
            end
         end
         default: begin
            if (stack_fill == 0) begin
               expected_rsps.push_back(make_rsp(STAT_EMPTY, '0, 0, 1'b1));
               empty_count++;
            end else begin
               // top to bottom, last flag on the bottom word
               for (i = 0; i < stack_fill; i++) begin
                  expected_rsps.push_back(make_rsp(STAT_OK, stack_words[stack_fill - 1 - i],
                                                   0, (i + 1 == stack_fill)));
               end
            end
         end
      endcase
      op_counts[int'(item.opcode)]++;
   endtask

   function automatic bit field_ok(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // request driver: fed from the pending queue, idles at random per phase
   always @(posedge clock) begin : req_driver
      int unsigned idle_pct;
      idle_pct = sender_idle_pct(phase);
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_stack_op(req_data);
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each transaction, drives ready with stalls
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_rsps.size() == 0) begin
               $display("%0t unexpected result: expected none actual %p", $time, rsp_data);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (!(field_ok("status", longint'(want.status), longint'(rsp_data.status)) &
                     field_ok("data", longint'(want.data), longint'(rsp_data.data)) &
                     field_ok("position", longint'(want.position), longint'(rsp_data.position)) &
                     field_ok("last", longint'(want.last), longint'(rsp_data.last)))) begin
                  errors++;
               end
            end
         end
         // one long hold-off so the block backs up and stalls its input
         if (phase == PH_BACKPRESSURE && !hold_done && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) begin
               hold_done = 1'b1;
            end
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct(phase));
         end
      end
   end

   // watchdog: cycles without progress while work is outstanding
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_valid)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t watchdog expired with %0d results outstanding", $time,
                  expected_rsps.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0) begin
         @(negedge clock);
      end
   endtask

   // random operations in bursts that lean towards filling or emptying
   task automatic queue_random_ops(input int unsigned count);
      int unsigned              n;
      int unsigned              push_pct;
      logic signed [DATA_W-1:0] value;
      opcode_type               op;
      push_pct = 50;
      for (n = 0; n < count; n++) begin
         if (n % 16 == 0) begin
            push_pct = 20 + 25 * $urandom_range(0, 2);
         end
         if ($urandom_range(0, 99) < push_pct) begin
            op = OP_PUSH;
         end else begin
            case ($urandom_range(0, 4))
               0, 1:    op = OP_POP;
               2, 3:    op = OP_SEARCH;
               default: op = OP_DISPLAY;
            endcase
         end
         case ($urandom_range(0, 3))
            0, 1: value = $urandom_range(0, 7);   // narrow range so searches hit
            2:    value = $urandom;
            default: begin
               case ($urandom_range(0, 3))
                  0:       value = {1'b1, {(DATA_W-1){1'b0}}};
                  1:       value = {1'b0, {(DATA_W-1){1'b1}}};
                  2:       value = '0;
                  default: value = '1;
               endcase
            end
         endcase
         pending_reqs.push_back(make_req(op, value));
      end
   endtask

   // stimulus sequence
   initial begin : stimulus
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end

      // empty stack corner cases
      phase = PH_STEADY;
      pending_reqs.push_back(make_req(OP_DISPLAY, '0));
      pending_reqs.push_back(make_req(OP_POP, '1));
      pending_reqs.push_back(make_req(OP_SEARCH, '0));
      // fill with extreme words, a duplicate zero, then overflow
      pending_reqs.push_back(make_req(OP_PUSH, {1'b1, {(DATA_W-1){1'b0}}}));
      pending_reqs.push_back(make_req(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}}));
      pending_reqs.push_back(make_req(OP_PUSH, '0));
      pending_reqs.push_back(make_req(OP_PUSH, '1));
      pending_reqs.push_back(make_req(OP_PUSH, 32'sh5555_5555));
      pending_reqs.push_back(make_req(OP_PUSH, 32'shAAAA_AAAA));
      pending_reqs.push_back(make_req(OP_PUSH, '0));
      pending_reqs.push_back(make_req(OP_PUSH, 32'sd1));
      pending_reqs.push_back(make_req(OP_PUSH, 32'sd99));
      // hits at top, second place (duplicate), bottom, and a miss
      pending_reqs.push_back(make_req(OP_SEARCH, 32'sd1));
      pending_reqs.push_back(make_req(OP_SEARCH, '0));
      pending_reqs.push_back(make_req(OP_SEARCH, {1'b1, {(DATA_W-1){1'b0}}}));
      pending_reqs.push_back(make_req(OP_SEARCH, 32'sd12345));
      pending_reqs.push_back(make_req(OP_DISPLAY, '0));
      repeat (DEPTH) pending_reqs.push_back(make_req(OP_POP, '0));
      pending_reqs.push_back(make_req(OP_POP, '0));
      wait_drained();

      // random traffic under each idling regime
      phase = PH_STEADY;
      queue_random_ops(100);
      wait_drained();
      phase = PH_SENDER_IDLE;
      queue_random_ops(100);
      wait_drained();
      phase = PH_RECEIVER_STALL;
      queue_random_ops(100);
      wait_drained();
      phase = PH_BOTH_IDLE;
      queue_random_ops(100);
      wait_drained();
      phase = PH_BACKPRESSURE;
      queue_random_ops(60);
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d push, %0d pop, %0d search, %0d display transactions; %0d results",
               op_counts[0], op_counts[1], op_counts[2], op_counts[3], results_seen);
      $display("corners: %0d overflow, %0d empty, %0d search hits, %0d misses, %0d-cycle hold",
               overflow_count, empty_count, hit_count, miss_count, HOLD_CYCLES);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/lss_pkg.sv
rtl/core/lss_ctrl.sv
rtl/core/lss_dp.sv
rtl/core/lifo_stack_with_search.sv
tb/tb_lifo_stack_with_search.sv
